### src/lsh_pkg.sv
// Shared types, codes and reset values for the link setup handshake block.
`default_nettype none
package lsh_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LSH_QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAG    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXTX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLE    = 3'd4;

  localparam logic [7:0]  RST_FLAG    = 8'h7E;
  localparam logic [7:0]  RST_ADDR    = 8'h03;
  localparam logic [15:0] RST_TIMEOUT = 16'd3;
  localparam logic [7:0]  RST_MAXTX   = 8'd3;
  localparam logic        RST_ROLE    = 1'b0;

  localparam logic [7:0] CTRL_SET = 8'h07;
  localparam logic [7:0] CTRL_UA  = 8'h03;

  localparam logic ROLE_INIT = 1'b0;
  localparam logic ROLE_RESP = 1'b1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_FAIL = 2'd3;

  localparam logic [2:0] PS_HUNT  = 3'd0;
  localparam logic [2:0] PS_FLAG  = 3'd1;
  localparam logic [2:0] PS_ADDR  = 3'd2;
  localparam logic [2:0] PS_CTRL  = 3'd3;
  localparam logic [2:0] PS_CHECK = 3'd4;

  localparam logic [2:0] BEAT_FLAG0 = 3'd0;
  localparam logic [2:0] BEAT_ADDR  = 3'd1;
  localparam logic [2:0] BEAT_CTRL  = 3'd2;
  localparam logic [2:0] BEAT_CHECK = 3'd3;
  localparam logic [2:0] BEAT_FLAG1 = 3'd4;

  typedef struct packed {
    logic [7:0]  flag_byte;
    logic [7:0]  address_byte;
    logic [15:0] timeout_ticks;
    logic [7:0]  max_transmissions;
    logic        role;
  } cfg_t;

  typedef struct packed {
    logic       send;
    logic [7:0] ctrl;
    logic       link_up;
    logic       failed;
  } job_t;

endpackage
`default_nettype wire

### src/lsh_ifs.sv
// Handshake channel interfaces: input commands, result beats, register writes.
`default_nettype none
interface lsh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface lsh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       last_result;
  logic       link_up;
  logic       failed;
  modport source (output valid, output tx_byte, output tx_valid, output last_result,
                  output link_up, output failed, input ready);
  modport sink (input valid, input tx_byte, input tx_valid, input last_result,
                input link_up, input failed, output ready);
endinterface

interface lsh_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  idx;
  logic [15:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface
`default_nettype wire

### src/link_setup_handshake.sv
// Link setup handshake: one command in, one or five result beats out.
// An accepted command is registered in the job queue and then in the output register.
// Throughput: one command per cycle when it sends nothing and the queue is not
// full; a command that sends a frame occupies the beat serializer for its five beats.
// Reset (rst_n, synchronous): registers to defaults, phase idle, queue empty.
`default_nettype none
module link_setup_handshake #(
  parameter int unsigned QUEUE_DEPTH = lsh_pkg::LSH_QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  lsh_in_if.sink     in_ch,
  lsh_out_if.source  out_ch,
  lsh_cfg_if.sink    cfg_ch
);
  import lsh_pkg::*;

  cfg_t cfg;
  job_t push_job, head_job;
  logic push, full, pop, empty;

  lsh_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  lsh_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_job  (push_job)
  );

  lsh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head_job)
  );

  lsh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (empty),
    .q_head  (head_job),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire

### src/lsh_cfg.sv
// Configuration register file with index decode.
`default_nettype none
module lsh_cfg (
  input  wire          clk,
  input  wire          rst_n,
  lsh_cfg_if.sink      cfg_ch,
  output lsh_pkg::cfg_t cfg
);
  import lsh_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        CFG_FLAG:    cfg_nxt.flag_byte = cfg_ch.data[7:0];
        CFG_ADDR:    cfg_nxt.address_byte = cfg_ch.data[7:0];
        CFG_TIMEOUT: cfg_nxt.timeout_ticks = cfg_ch.data;
        CFG_MAXTX:   cfg_nxt.max_transmissions = cfg_ch.data[7:0];
        CFG_ROLE:    cfg_nxt.role = cfg_ch.data[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte <= RST_FLAG;
      cfg_r.address_byte <= RST_ADDR;
      cfg_r.timeout_ticks <= RST_TIMEOUT;
      cfg_r.max_transmissions <= RST_MAXTX;
      cfg_r.role <= RST_ROLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule
`default_nettype wire

### src/lsh_front.sv
// Front end: takes commands, runs recognizer, timer and phase, issues one job per command.
`default_nettype none
module lsh_front (
  input  wire           clk,
  input  wire           rst_n,
  input  lsh_pkg::cfg_t cfg,
  lsh_in_if.sink        in_ch,
  input  wire           q_full,
  output logic          q_push,
  output lsh_pkg::job_t q_job
);
  import lsh_pkg::*;

  typedef struct packed {
    logic [2:0] ns;
    logic       hit;
  } rec_t;

  function automatic rec_t recog(input logic [2:0] s, input logic [7:0] c,
                                 input logic [7:0] ctrl, input logic [7:0] flag,
                                 input logic [7:0] addr);
    rec_t r;
    r.ns = PS_HUNT;
    r.hit = 1'b0;
    unique case (s)
      PS_HUNT:  r.ns = (c == flag) ? PS_FLAG : PS_HUNT;
      PS_FLAG:  r.ns = (c == addr) ? PS_ADDR : (c == flag) ? PS_FLAG : PS_HUNT;
      PS_ADDR:  r.ns = (c == ctrl) ? PS_CTRL : (c == flag) ? PS_FLAG : PS_HUNT;
      PS_CTRL:  r.ns = (c == (addr ^ ctrl)) ? PS_CHECK : (c == flag) ? PS_FLAG : PS_HUNT;
      PS_CHECK: r.hit = (c == flag);
      default:  r.ns = (c == flag) ? PS_FLAG : PS_HUNT;
    endcase
    return r;
  endfunction

  logic [2:0]  ps_r, ps_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  attempt_r, attempt_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        send;
  logic [7:0]  ctrl;
  logic [15:0] tinc;
  rec_t        rec;
  logic        accept;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && !q_full;
  assign tinc = timer_r + 16'd1;
  assign rec = recog(ps_r, in_ch.rx_byte, (cfg.role == ROLE_RESP) ? CTRL_SET : CTRL_UA,
                     cfg.flag_byte, cfg.address_byte);

  always_comb begin
    ps_nxt = ps_r;
    timer_nxt = timer_r;
    attempt_nxt = attempt_r;
    phase_nxt = phase_r;
    send = 1'b0;
    ctrl = CTRL_SET;
    unique case (in_ch.command)
      CMD_START: begin
        ps_nxt = PS_HUNT;
        timer_nxt = '0;
        if (cfg.role == ROLE_INIT) begin
          attempt_nxt = 8'd1;
          phase_nxt = PH_WAIT;
          send = 1'b1;
        end else begin
          attempt_nxt = '0;
          phase_nxt = PH_IDLE;
        end
      end
      CMD_BYTE: begin
        if (cfg.role == ROLE_RESP) begin
          ps_nxt = rec.ns;
          if (rec.hit) begin
            phase_nxt = PH_DONE;
            send = 1'b1;
            ctrl = CTRL_UA;
          end
        end else if (phase_r == PH_WAIT) begin
          ps_nxt = rec.ns;
          if (rec.hit) begin
            phase_nxt = PH_DONE;
            timer_nxt = '0;
          end
        end
      end
      CMD_TICK: begin
        if (cfg.role == ROLE_INIT && phase_r == PH_WAIT) begin
          timer_nxt = tinc;
          if (tinc >= cfg.timeout_ticks || tinc == 16'd0) begin
            timer_nxt = '0;
            if (attempt_r >= cfg.max_transmissions) begin
              phase_nxt = PH_FAIL;
            end else begin
              attempt_nxt = attempt_r + 8'd1;
              send = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign q_push = accept;
  assign q_job.send = send;
  assign q_job.ctrl = ctrl;
  assign q_job.link_up = (phase_nxt == PH_DONE);
  assign q_job.failed = (phase_nxt == PH_FAIL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= PS_HUNT;
      timer_r <= '0;
      attempt_r <= '0;
      phase_r <= PH_IDLE;
    end else if (accept) begin
      ps_r <= ps_nxt;
      timer_r <= timer_nxt;
      attempt_r <= attempt_nxt;
      phase_r <= phase_nxt;
    end
  end
endmodule
`default_nettype wire

### src/lsh_fifo.sv
// Small job queue between front and back ends.
`default_nettype none
module lsh_fifo #(
  parameter int unsigned DEPTH = lsh_pkg::LSH_QUEUE_DEPTH
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  lsh_pkg::job_t push_job,
  output logic          full,
  input  wire           pop,
  output logic          empty,
  output lsh_pkg::job_t head
);
  import lsh_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full = (cnt_r == FULLC);
  assign empty = (cnt_r == '0);
  assign head = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

### src/lsh_back.sv
// Back end: expands queued jobs into result beats through an output register.
`default_nettype none
module lsh_back (
  input  wire           clk,
  input  wire           rst_n,
  input  lsh_pkg::cfg_t cfg,
  input  wire           q_empty,
  input  lsh_pkg::job_t q_head,
  output logic          q_pop,
  lsh_out_if.source     out_ch
);
  import lsh_pkg::*;

  logic [2:0] beat_r;
  logic       ov_r;
  logic [7:0] byte_r;
  logic       txv_r, last_r, up_r, fail_r;
  logic       load;
  logic       is_last;
  logic [7:0] byte_nxt;

  assign load = (!ov_r || out_ch.ready) && !q_empty;
  assign is_last = !q_head.send || (beat_r == BEAT_FLAG1);
  assign q_pop = load && is_last;

  always_comb begin
    byte_nxt = '0;
    if (q_head.send) begin
      unique case (beat_r)
        BEAT_FLAG0: byte_nxt = cfg.flag_byte;
        BEAT_ADDR:  byte_nxt = cfg.address_byte;
        BEAT_CTRL:  byte_nxt = q_head.ctrl;
        BEAT_CHECK: byte_nxt = cfg.address_byte ^ q_head.ctrl;
        BEAT_FLAG1: byte_nxt = cfg.flag_byte;
        default:    byte_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      beat_r <= BEAT_FLAG0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
        beat_r <= is_last ? BEAT_FLAG0 : beat_r + 3'd1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      txv_r <= q_head.send;
      last_r <= is_last;
      up_r <= q_head.link_up;
      fail_r <= q_head.failed;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.tx_byte = byte_r;
  assign out_ch.tx_valid = txv_r;
  assign out_ch.last_result = last_r;
  assign out_ch.link_up = up_r;
  assign out_ch.failed = fail_r;
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for link_setup_handshake: directed table, then randomized phases.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsh_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 38;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last_result;
    logic       link_up;
    logic       failed;
  } beat_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic       typed;
    beat_t      first;
  } row_t;

  localparam beat_t LONE_IDLE = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam beat_t LONE_UP   = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam beat_t SET_HEAD  = '{RST_FLAG, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam beat_t NO_BEAT   = '0;

  logic clk = 1'b0;
  logic rst_n;

  lsh_in_if  in_ch();
  lsh_out_if out_ch();
  lsh_cfg_if cfg_ch();

  link_setup_handshake i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  lk_flag, lk_addr, lk_maxtx, lk_tries;
  logic [15:0] lk_tmo, lk_timer;
  logic        lk_role;
  logic [2:0]  lk_ps;
  logic [1:0]  lk_phase;

  beat_t tx_beats_due[$];
  beat_t step_beats[$];

  int errors = 0;
  int items_done = 0;
  int cycles = 0;
  int idle_mode = 0;
  int holds_asked = 0;
  int holds_taken = 0;
  int rx_hold = 0;
  int rx_gap = 0;

  row_t dir_rows [0:22] = '{
    '{CMD_TICK,  8'h00, 1'b1, LONE_IDLE},
    '{CMD_BYTE,  8'h7E, 1'b1, LONE_IDLE},
    '{CMD_NONE,  8'hA5, 1'b1, LONE_IDLE},
    '{CMD_START, 8'hFF, 1'b1, SET_HEAD},
    '{CMD_BYTE,  8'h7E, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h7E, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h03, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h7E, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h03, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h03, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h55, 1'b0, NO_BEAT},
    '{CMD_TICK,  8'hFF, 1'b0, NO_BEAT},
    '{CMD_TICK,  8'h00, 1'b0, NO_BEAT},
    '{CMD_TICK,  8'h00, 1'b1, SET_HEAD},
    '{CMD_BYTE,  8'h7E, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h03, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h03, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h00, 1'b0, NO_BEAT},
    '{CMD_BYTE,  8'h7E, 1'b1, LONE_UP},
    '{CMD_TICK,  8'h00, 1'b1, LONE_UP},
    '{CMD_BYTE,  8'h7E, 1'b1, LONE_UP},
    '{CMD_START, 8'h00, 1'b1, SET_HEAD},
    '{CMD_BYTE,  8'h00, 1'b0, NO_BEAT}
  };

  function automatic void link_reset();
    lk_flag  = RST_FLAG;
    lk_addr  = RST_ADDR;
    lk_tmo   = RST_TIMEOUT;
    lk_maxtx = RST_MAXTX;
    lk_role  = RST_ROLE;
    lk_ps    = PS_HUNT;
    lk_timer = '0;
    lk_tries = '0;
    lk_phase = PH_IDLE;
  endfunction

  function automatic void reg_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FLAG:    lk_flag  = data[7:0];
      CFG_ADDR:    lk_addr  = data[7:0];
      CFG_TIMEOUT: lk_tmo   = data;
      CFG_MAXTX:   lk_maxtx = data[7:0];
      CFG_ROLE:    lk_role  = data[0];
      default: ;
    endcase
  endfunction

  // one byte into the frame recognizer; 1 when a full frame with ctrl just closed
  function automatic logic frame_seen(input logic [7:0] c, input logic [7:0] ctrl);
    logic [2:0] nxt;
    logic hit;
    nxt = PS_HUNT;
    hit = 1'b0;
    case (lk_ps)
      PS_HUNT: if (c == lk_flag) nxt = PS_FLAG;
      PS_FLAG: begin
        if (c == lk_addr) nxt = PS_ADDR;
        else if (c == lk_flag) nxt = PS_FLAG;
      end
      PS_ADDR: begin
        if (c == ctrl) nxt = PS_CTRL;
        else if (c == lk_flag) nxt = PS_FLAG;
      end
      PS_CTRL: begin
        if (c == (lk_addr ^ ctrl)) nxt = PS_CHECK;
        else if (c == lk_flag) nxt = PS_FLAG;
      end
      PS_CHECK: hit = (c == lk_flag);
      default: if (c == lk_flag) nxt = PS_FLAG;
    endcase
    lk_ps = nxt;
    return hit;
  endfunction

  function automatic void add_frame(input logic [7:0] ctrl);
    step_beats.push_back('{lk_flag, 1'b1, 1'b0, 1'b0, 1'b0});
    step_beats.push_back('{lk_addr, 1'b1, 1'b0, 1'b0, 1'b0});
    step_beats.push_back('{ctrl, 1'b1, 1'b0, 1'b0, 1'b0});
    step_beats.push_back('{lk_addr ^ ctrl, 1'b1, 1'b0, 1'b0, 1'b0});
    step_beats.push_back('{lk_flag, 1'b1, 1'b0, 1'b0, 1'b0});
  endfunction

  // advances the predictor by one command, queues its beats, returns the first one
  function automatic beat_t link_step(input logic [1:0] cmd, input logic [7:0] b);
    step_beats.delete();
    case (cmd)
      CMD_START: begin
        lk_ps = PS_HUNT;
        lk_timer = '0;
        if (lk_role == ROLE_INIT) begin
          lk_tries = 8'd1;
          lk_phase = PH_WAIT;
          add_frame(CTRL_SET);
        end else begin
          lk_tries = '0;
          lk_phase = PH_IDLE;
        end
      end
      CMD_BYTE: begin
        if (lk_role == ROLE_RESP) begin
          if (frame_seen(b, CTRL_SET)) begin
            lk_phase = PH_DONE;
            add_frame(CTRL_UA);
          end
        end else if (lk_phase == PH_WAIT) begin
          if (frame_seen(b, CTRL_UA)) begin
            lk_phase = PH_DONE;
            lk_timer = '0;
          end
        end
      end
      CMD_TICK: begin
        if (lk_role == ROLE_INIT && lk_phase == PH_WAIT) begin
          lk_timer = lk_timer + 16'd1;
          if (lk_timer >= lk_tmo || lk_timer == 16'd0) begin
            lk_timer = '0;
            if (lk_tries >= lk_maxtx) begin
              lk_phase = PH_FAIL;
            end else begin
              lk_tries = lk_tries + 8'd1;
              add_frame(CTRL_SET);
            end
          end
        end
      end
      default: ;
    endcase
    if (step_beats.size() == 0) step_beats.push_back(NO_BEAT);
    foreach (step_beats[i]) begin
      step_beats[i].link_up = (lk_phase == PH_DONE);
      step_beats[i].failed = (lk_phase == PH_FAIL);
      step_beats[i].last_result = (i == step_beats.size() - 1);
      tx_beats_due.push_back(step_beats[i]);
    end
    return step_beats[0];
  endfunction

  function automatic void flag_error(input string what, input beat_t want, input beat_t got);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected tx_byte=%h tx_valid=%b last=%b link_up=%b failed=%b,",
               what, want.tx_byte, want.tx_valid, want.last_result, want.link_up, want.failed,
               " got tx_byte=%h tx_valid=%b last=%b link_up=%b failed=%b",
               got.tx_byte, got.tx_valid, got.last_result, got.link_up, got.failed);
  endfunction

  function automatic void check_beat();
    beat_t got, want;
    got = '{out_ch.tx_byte, out_ch.tx_valid, out_ch.last_result, out_ch.link_up, out_ch.failed};
    if (tx_beats_due.size() == 0) begin
      flag_error("beat with nothing pending", NO_BEAT, got);
    end else begin
      want = tx_beats_due.pop_front();
      if (got.tx_byte !== want.tx_byte || got.tx_valid !== want.tx_valid ||
          got.last_result !== want.last_result || got.link_up !== want.link_up ||
          got.failed !== want.failed)
        flag_error("result beat", want, got);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side: checks beats, stalls at random, takes long holds on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_beat();
      if (holds_taken != holds_asked) begin
        holds_taken = holds_asked;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        rx_gap = idle_mode[1] ? pick_gap() : 0;
        out_ch.ready <= (rx_gap == 0);
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, output beat_t first);
    int gap;
    gap = idle_mode[0] ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    first = link_step(cmd, b);
    if (cmd != CMD_NONE) items_done++;
  endtask

  task automatic put(input logic [1:0] cmd, input logic [7:0] b);
    beat_t first;
    send_item(cmd, b, first);
  endtask

  task automatic put_frame(input logic [7:0] ctrl);
    logic [7:0] bytes [5];
    int k;
    bytes = '{lk_flag, lk_addr, ctrl, lk_addr ^ ctrl, lk_flag};
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, 4);
      bytes[k] = $urandom_range(0, 1) ? lk_flag : 8'($urandom_range(0, 255));
    end
    foreach (bytes[i]) put(CMD_BYTE, bytes[i]);
  endtask

  task automatic put_ticks();
    int n;
    n = $urandom_range(1, (lk_tmo < 16'd8) ? int'(lk_tmo) + 1 : 4);
    repeat (n) put(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_write(idx, data);
  endtask

  task automatic set_regs(input logic [7:0] f, input logic [7:0] a, input logic [15:0] t,
                          input logic [7:0] m, input logic r);
    write_reg(CFG_SPARE_LO + 3'($urandom_range(0, 2)), 16'($urandom));
    write_reg(CFG_FLAG, {8'($urandom), f});
    write_reg(CFG_ADDR, {8'($urandom), a});
    write_reg(CFG_TIMEOUT, t);
    write_reg(CFG_MAXTX, {8'($urandom), m});
    write_reg(CFG_ROLE, {15'($urandom), r});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input int p);
    case (p)
      0: set_regs(8'h00, 8'hFF, 16'd1, 8'd1, ROLE_INIT);
      1: set_regs(8'hFF, 8'h00, 16'd0, 8'd0, ROLE_INIT);
      2: set_regs(RST_FLAG, RST_ADDR, 16'hFFFF, 8'hFF, ROLE_INIT);
      3: set_regs(RST_FLAG, RST_ADDR, RST_TIMEOUT, RST_MAXTX, ROLE_RESP);
      4: set_regs(8'h00, 8'hFF, 16'd1, 8'd1, ROLE_RESP);
      5: set_regs(8'h5A, 8'h5A, 16'd2, 8'd2, ROLE_INIT);
      default: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
                        1'($urandom_range(0, 1)));
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tx_beats_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int quota);
    int base, r;
    base = items_done;
    put(CMD_START, 8'($urandom_range(0, 255)));
    while (items_done - base < quota) begin
      r = $urandom_range(0, 99);
      if (lk_role == ROLE_INIT) begin
        if (lk_phase != PH_WAIT && $urandom_range(0, 2) != 0) put(CMD_START, 8'($urandom));
        else if (r < 35) put_frame(CTRL_UA);
        else if (r < 65) put_ticks();
        else if (r < 80) put(CMD_BYTE, 8'($urandom_range(0, 255)));
        else if (r < 88) put(CMD_START, 8'($urandom));
        else if (r < 95) put_frame(CTRL_SET);
        else put(CMD_NONE, 8'($urandom));
      end else begin
        if (r < 45) put_frame(CTRL_SET);
        else if (r < 55) put_frame(CTRL_UA);
        else if (r < 75) put(CMD_BYTE, 8'($urandom_range(0, 255)));
        else if (r < 85) put_ticks();
        else if (r < 93) put(CMD_START, 8'($urandom));
        else put(CMD_NONE, 8'($urandom));
      end
    end
  endtask

  initial begin
    beat_t first;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_START;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = CFG_FLAG;
    cfg_ch.data = '0;
    link_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    idle_mode = 3;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].rx_byte, first);
      if (dir_rows[i].typed && first !== dir_rows[i].first)
        flag_error("directed row", dir_rows[i].first, first);
    end
    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(p);
      idle_mode = p % 4;
      if (p % 3 == 2) holds_asked++;
      run_phase(PHASE_ITEMS);
    end
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
